@@ hw/rtl/trd_pkg.sv @@
// TGA run-length pixel decoder: shared types and constants.
// No dependencies; used by trd_decode, the top level and the bench.
package trd_pkg;

   localparam int unsigned HDR_LEN     = 18;
   localparam int unsigned IDX_TYPE    = 2;
   localparam int unsigned IDX_WIDTH_L = 12;
   localparam int unsigned IDX_WIDTH_H = 13;
   localparam int unsigned IDX_HGT_L   = 14;
   localparam int unsigned IDX_HGT_H   = 15;
   localparam int unsigned IDX_DEPTH   = 16;

   localparam logic [7:0] TYPE_RAW  = 8'd2;
   localparam logic [7:0] DEPTH_24  = 8'd24;
   localparam logic [7:0] DEPTH_32  = 8'd32;
   localparam logic [7:0] RUN_MASK  = 8'd127;

   localparam logic STATUS_PIXEL = 1'b0;
   localparam logic STATUS_DEPTH = 1'b1;

   typedef enum logic [2:0] {
      PH_HEADER = 3'b001,
      PH_PIXELS = 3'b010,
      PH_DONE   = 3'b100
   } phase_type;

   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [7:0]  repeat_count;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic        is_last;
      logic        status;
   } rsp_type;

endpackage

@@ hw/rtl/trd_req_if.sv @@
// Input byte channel of the TGA decoder: valid/ready plus one file byte.
// No dependencies.
interface trd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

@@ hw/rtl/trd_rsp_if.sv @@
// Result channel of the TGA decoder: valid/ready plus one decoded pixel.
// No dependencies.
interface trd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  red;
   logic [7:0]  green;
   logic [7:0]  blue;
   logic [7:0]  alpha;
   logic [7:0]  repeat_count;
   logic [15:0] image_width;
   logic [15:0] image_height;
   logic        is_last;
   logic        status;

   modport source (output valid, output red, output green, output blue, output alpha,
                   output repeat_count, output image_width, output image_height,
                   output is_last, output status, input ready);
   modport sink   (input valid, input red, input green, input blue, input alpha,
                   input repeat_count, input image_width, input image_height,
                   input is_last, input status, output ready);
endinterface

@@ hw/rtl/trd_decode.sv @@
// TGA decoder state: header parse, packet tracking, channel gather, run clipping.
// Depends on trd_pkg. One byte is consumed on each cycle with step high.
module trd_decode (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [7:0]       data_byte,
   output logic             emit,
   output trd_pkg::rsp_type result
);

   trd_pkg::phase_type phase_ff, phase_in;
   logic [4:0]  hdr_idx_ff, hdr_idx_in;
   logic        uncomp_ff, uncomp_in;
   logic        has_alpha_ff, has_alpha_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [31:0] pix_left_ff, pix_left_in;
   logic [7:0]  pkt_left_ff, pkt_left_in;
   logic        pkt_run_ff, pkt_run_in;
   logic [1:0]  chan_ff, chan_in;
   logic [7:0]  chan_buf_ff [3];
   logic [7:0]  chan_buf_in [3];

   logic [31:0] pix_total;
   logic [1:0]  last_chan;
   logic [7:0]  rep;
   logic [31:0] pix_after;

   assign pix_total = width_ff * height_ff;
   assign last_chan = has_alpha_ff ? 2'd3 : 2'd2;

   always_comb begin
      phase_in     = phase_ff;
      hdr_idx_in   = hdr_idx_ff;
      uncomp_in    = uncomp_ff;
      has_alpha_in = has_alpha_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      pix_left_in  = pix_left_ff;
      pkt_left_in  = pkt_left_ff;
      pkt_run_in   = pkt_run_ff;
      chan_in      = chan_ff;
      chan_buf_in  = chan_buf_ff;
      emit         = 1'b0;
      rep          = 8'd1;
      pix_after    = pix_left_ff;
      result       = '0;

      if (step) begin
         case (phase_ff)
            trd_pkg::PH_HEADER: begin
               if (hdr_idx_ff == 5'(trd_pkg::IDX_TYPE)) begin
                  uncomp_in = (data_byte == trd_pkg::TYPE_RAW);
               end
               if (hdr_idx_ff == 5'(trd_pkg::IDX_WIDTH_L)) begin
                  width_in = {width_ff[15:8], data_byte};
               end
               if (hdr_idx_ff == 5'(trd_pkg::IDX_WIDTH_H)) begin
                  width_in = {data_byte, width_ff[7:0]};
               end
               if (hdr_idx_ff == 5'(trd_pkg::IDX_HGT_L)) begin
                  height_in = {height_ff[15:8], data_byte};
               end
               if (hdr_idx_ff == 5'(trd_pkg::IDX_HGT_H)) begin
                  height_in = {data_byte, height_ff[7:0]};
               end
               if (hdr_idx_ff == 5'(trd_pkg::IDX_DEPTH)) begin
                  has_alpha_in = (data_byte == trd_pkg::DEPTH_32);
               end
               if (hdr_idx_ff == 5'(trd_pkg::IDX_DEPTH) &&
                   !(data_byte inside {trd_pkg::DEPTH_24, trd_pkg::DEPTH_32})) begin
                  phase_in = trd_pkg::PH_DONE;
                  emit     = 1'b1;
                  result.is_last = 1'b1;
                  result.status  = trd_pkg::STATUS_DEPTH;
               end else if (hdr_idx_ff == 5'(trd_pkg::HDR_LEN - 1)) begin
                  pix_left_in = pix_total;
                  pkt_left_in = '0;
                  pkt_run_in  = 1'b0;
                  chan_in     = '0;
                  phase_in    = (pix_total != '0) ? trd_pkg::PH_PIXELS : trd_pkg::PH_DONE;
               end else begin
                  hdr_idx_in = hdr_idx_ff + 5'd1;
               end
            end
            trd_pkg::PH_PIXELS: begin
               if (!uncomp_ff && pkt_left_ff == '0) begin
                  // packet header byte
                  pkt_run_in  = data_byte[7];
                  pkt_left_in = (data_byte & trd_pkg::RUN_MASK) + 8'd1;
                  chan_in     = '0;
               end else if (chan_ff < last_chan) begin
                  chan_buf_in[chan_ff] = data_byte;
                  chan_in = chan_ff + 2'd1;
               end else begin
                  chan_in = '0;
                  if (!uncomp_ff) begin
                     if (pkt_run_ff) begin
                        rep         = pkt_left_ff;
                        pkt_left_in = '0;
                     end else begin
                        pkt_left_in = pkt_left_ff - 8'd1;
                     end
                  end
                  if (pix_left_ff[31:8] == '0 && pix_left_ff[7:0] < rep) begin
                     rep = pix_left_ff[7:0];
                  end
                  pix_after   = pix_left_ff - {24'd0, rep};
                  pix_left_in = pix_after;
                  if (pix_after == '0) begin
                     phase_in = trd_pkg::PH_DONE;
                  end
                  emit = 1'b1;
                  if (has_alpha_ff) begin
                     result.red   = chan_buf_ff[2];
                     result.alpha = data_byte;
                  end else begin
                     result.red   = data_byte;
                  end
                  result.green        = chan_buf_ff[1];
                  result.blue         = chan_buf_ff[0];
                  result.repeat_count = rep;
                  result.is_last      = (pix_after == '0);
                  result.status       = trd_pkg::STATUS_PIXEL;
               end
            end
            default: begin
            end
         endcase
      end
      result.image_width  = width_in;
      result.image_height = height_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= trd_pkg::PH_HEADER;
         hdr_idx_ff   <= '0;
         uncomp_ff    <= 1'b0;
         has_alpha_ff <= 1'b0;
         width_ff     <= '0;
         height_ff    <= '0;
         pix_left_ff  <= '0;
         pkt_left_ff  <= '0;
         pkt_run_ff   <= 1'b0;
         chan_ff      <= '0;
         chan_buf_ff  <= '{default: '0};
      end else begin
         phase_ff     <= phase_in;
         hdr_idx_ff   <= hdr_idx_in;
         uncomp_ff    <= uncomp_in;
         has_alpha_ff <= has_alpha_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         pix_left_ff  <= pix_left_in;
         pkt_left_ff  <= pkt_left_in;
         pkt_run_ff   <= pkt_run_in;
         chan_ff      <= chan_in;
         chan_buf_ff  <= chan_buf_in;
      end
   end

endmodule

@@ hw/rtl/tga_rle_pixel_decoder.sv @@
// TGA run-length pixel decoder, top level: input register, decoder, result register.
// Depends on trd_pkg, trd_req_if, trd_rsp_if and trd_decode.
//
//   channel  dir  payload                                        moves
//   req      in   data_byte                                      one file byte per item
//   rsp      out  red green blue alpha repeat_count image_width  one pixel or error per item
//                 image_height is_last status
//
// One item per cycle while results are taken; a byte lands in the input register when
// accepted and a result it completes enters the result register after one decode pass.
// Synchronous reset returns the decoder to the start of a header.
// A stalled result holds the decode step; the input register still takes one byte,
// then req.ready drops until the result is taken.
module tga_rle_pixel_decoder (
   input logic    clock,
   input logic    reset,
   trd_req_if.sink   req,
   trd_rsp_if.source rsp
);

   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff;
   logic             out_valid_ff, out_valid_in;
   trd_pkg::rsp_type out_ff;
   logic             out_free;
   logic             advance;
   logic             emit;
   trd_pkg::rsp_type result;

   assign out_free  = !out_valid_ff || rsp.ready;
   assign advance   = in_valid_ff && out_free;
   assign req.ready = !in_valid_ff || out_free;

   trd_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_byte_ff),
      .emit      (emit),
      .result    (result)
   );

   always_comb begin
      in_valid_in  = (req.valid && req.ready) || (in_valid_ff && !advance);
      out_valid_in = (out_valid_ff && !rsp.ready) || (advance && emit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_byte_ff <= req.data_byte;
      end
      if (advance && emit) begin
         out_ff <= result;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.red          = out_ff.red;
   assign rsp.green        = out_ff.green;
   assign rsp.blue         = out_ff.blue;
   assign rsp.alpha        = out_ff.alpha;
   assign rsp.repeat_count = out_ff.repeat_count;
   assign rsp.image_width  = out_ff.image_width;
   assign rsp.image_height = out_ff.image_height;
   assign rsp.is_last      = out_ff.is_last;
   assign rsp.status       = out_ff.status;

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for tga_rle_pixel_decoder: builds one TGA file, streams it in
// byte by byte and checks every result against a behavioral decoder kept in step or a pinned want.
// Depends on trd_pkg, trd_req_if, trd_rsp_if and the decoder RTL.
module tb;

   localparam logic [7:0]  TYPE_RLE    = 8'd10;
   localparam int unsigned PIXEL_BYTES = 1100;
   localparam int unsigned HOLD_CYCLES = 80;
   localparam int unsigned TAIL_CYCLES = 20;

   typedef struct {
      logic [7:0]       data;
      bit               pinned;
      trd_pkg::rsp_type want;
   } file_entry_type;

   // packet byte (run-length files only), B, G, R, A and the repeat count of a run
   typedef struct packed {
      logic [7:0] pkt;
      logic [7:0] bl;
      logic [7:0] gr;
      logic [7:0] rd;
      logic [7:0] al;
      logic [7:0] rep;
   } directed_row_type;

   localparam directed_row_type DIRECTED [3] = '{
      '{pkt: 8'h80, bl: 8'h00, gr: 8'hFF, rd: 8'h7F, al: 8'h80, rep: 8'd1},
      '{pkt: 8'hFF, bl: 8'hFF, gr: 8'hFF, rd: 8'hFF, al: 8'hFF, rep: 8'd128},
      '{pkt: 8'h00, bl: 8'h12, gr: 8'h34, rd: 8'h56, al: 8'h00, rep: 8'd1}
   };

   logic clock;
   logic reset;

   trd_req_if req_ch ();
   trd_rsp_if rsp_ch ();

   tga_rle_pixel_decoder i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   file_entry_type   tga_file[$];
   trd_pkg::rsp_type pixel_q[$];
   int unsigned mismatch_cnt = 0;
   int unsigned accepted_cnt = 0;
   int unsigned checked_cnt  = 0;
   int unsigned idle_phase   = 0;
   bit          hold_go      = 0;
   logic [7:0]  file_type, file_depth;
   logic [15:0] file_w, file_h;

   // behavioral decoder state
   trd_pkg::phase_type dec_phase;
   logic [4:0]  dec_hdr_pos;
   logic        dec_raw, dec_alpha;
   logic [15:0] dec_w, dec_h;
   logic [31:0] dec_left;
   logic [7:0]  dec_pkt_left;
   logic        dec_pkt_run;
   logic [1:0]  dec_chan;
   logic [7:0]  dec_buf [3];

   task automatic clear_decoder();
      dec_phase    = trd_pkg::PH_HEADER;
      dec_hdr_pos  = '0;
      dec_raw      = 1'b0;
      dec_alpha    = 1'b0;
      dec_w        = '0;
      dec_h        = '0;
      dec_left     = '0;
      dec_pkt_left = '0;
      dec_pkt_run  = 1'b0;
      dec_chan     = '0;
      foreach (dec_buf[i]) dec_buf[i] = '0;
   endtask

   task automatic decode_byte(input logic [7:0] b, output bit emitted,
                              output trd_pkg::rsp_type pix);
      logic [1:0]  last_ch;
      logic [31:0] rep;
      emitted = 1'b0;
      pix     = '0;
      if (dec_phase == trd_pkg::PH_HEADER) begin
         case (dec_hdr_pos)
            trd_pkg::IDX_TYPE:    dec_raw = (b == trd_pkg::TYPE_RAW);
            trd_pkg::IDX_WIDTH_L: dec_w[7:0] = b;
            trd_pkg::IDX_WIDTH_H: dec_w[15:8] = b;
            trd_pkg::IDX_HGT_L:   dec_h[7:0] = b;
            trd_pkg::IDX_HGT_H:   dec_h[15:8] = b;
            trd_pkg::IDX_DEPTH: begin
               dec_alpha = (b == trd_pkg::DEPTH_32);
               if (!(b inside {trd_pkg::DEPTH_24, trd_pkg::DEPTH_32})) begin
                  dec_phase        = trd_pkg::PH_DONE;
                  emitted          = 1'b1;
                  pix.image_width  = dec_w;
                  pix.image_height = dec_h;
                  pix.is_last      = 1'b1;
                  pix.status       = trd_pkg::STATUS_DEPTH;
               end
            end
            default: ;
         endcase
         if (!emitted) begin
            if (dec_hdr_pos + 1 >= trd_pkg::HDR_LEN) begin
               dec_left     = 32'(dec_w) * 32'(dec_h);
               dec_pkt_left = '0;
               dec_pkt_run  = 1'b0;
               dec_chan     = '0;
               dec_phase    = (dec_left != 0) ? trd_pkg::PH_PIXELS : trd_pkg::PH_DONE;
            end else begin
               dec_hdr_pos = dec_hdr_pos + 5'd1;
            end
         end
      end else if (dec_phase == trd_pkg::PH_PIXELS) begin
         last_ch = dec_alpha ? 2'd3 : 2'd2;
         if (!dec_raw && dec_pkt_left == 0) begin
            // packet header: top bit selects a run, 128 included
            dec_pkt_run  = b[7];
            dec_pkt_left = (b & trd_pkg::RUN_MASK) + 8'd1;
            dec_chan     = '0;
         end else if (dec_chan < last_ch) begin
            dec_buf[dec_chan] = b;
            dec_chan          = dec_chan + 2'd1;
         end else begin
            dec_chan  = '0;
            pix.red   = dec_alpha ? dec_buf[2] : b;
            pix.green = dec_buf[1];
            pix.blue  = dec_buf[0];
            pix.alpha = dec_alpha ? b : 8'd0;
            if (dec_raw) begin
               rep = 1;
            end else if (dec_pkt_run) begin
               rep          = 32'(dec_pkt_left);
               dec_pkt_left = '0;
            end else begin
               rep          = 1;
               dec_pkt_left = dec_pkt_left - 8'd1;
            end
            if (rep > dec_left) rep = dec_left;
            dec_left = dec_left - rep;
            if (dec_left == 0) dec_phase = trd_pkg::PH_DONE;
            pix.repeat_count = rep[7:0];
            pix.image_width  = dec_w;
            pix.image_height = dec_h;
            pix.is_last      = (dec_left == 0);
            pix.status       = trd_pkg::STATUS_PIXEL;
            emitted          = 1'b1;
         end
      end
   endtask

   task automatic push_byte(input logic [7:0] d);
      tga_file.push_back('{data: d, pinned: 1'b0, want: '0});
   endtask

   // bytes go out as B, G, R and A for 32-bit images
   task automatic push_pixel(input bit with_alpha, input logic [7:0] bl, gr, rd, al,
                             input bit pin, input logic [7:0] rep);
      trd_pkg::rsp_type want;
      want = '0;
      push_byte(bl);
      push_byte(gr);
      push_byte(rd);
      if (with_alpha) push_byte(al);
      if (pin) begin
         want.red          = rd;
         want.green        = gr;
         want.blue         = bl;
         want.alpha        = with_alpha ? al : 8'd0;
         want.repeat_count = rep;
         want.status       = trd_pkg::STATUS_PIXEL;
         tga_file[$].pinned = 1'b1;
         tga_file[$].want   = want;
      end
   endtask

   task automatic random_pixel(input bit with_alpha);
      case ($urandom_range(0, 7))
         0: push_pixel(with_alpha, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'd0);
         1: push_pixel(with_alpha, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 8'd0);
         default: push_pixel(with_alpha, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0, 8'd0);
      endcase
   endtask

   // Pixel data first so that the header can carry a size that clips the last packet.
   task automatic build_file();
      bit             with_alpha;
      bit             rle;
      int unsigned    pixels, total, h, len, n, k;
      logic [7:0]     d;
      file_entry_type head[$];
      with_alpha = $urandom_range(0, 1);
      file_depth = with_alpha ? trd_pkg::DEPTH_32 : trd_pkg::DEPTH_24;
      case ($urandom_range(0, 3))
         0: file_type = trd_pkg::TYPE_RAW;
         1: begin
            file_type = 8'($urandom_range(0, 255));
            if (file_type == trd_pkg::TYPE_RAW) file_type = TYPE_RLE;
         end
         default: file_type = TYPE_RLE;
      endcase
      rle = (file_type != trd_pkg::TYPE_RAW);

      // directed rows: run of one from byte 128, a full run of 128, a single raw pixel
      pixels = 0;
      foreach (DIRECTED[r]) begin
         if (rle) push_byte(DIRECTED[r].pkt);
         push_pixel(with_alpha, DIRECTED[r].bl, DIRECTED[r].gr, DIRECTED[r].rd,
                    DIRECTED[r].al, 1'b1, rle ? DIRECTED[r].rep : 8'd1);
         pixels += rle ? int'(DIRECTED[r].rep) : 1;
      end

      while (tga_file.size() < PIXEL_BYTES) begin
         if (!rle) begin
            random_pixel(with_alpha);
            pixels++;
         end else if ($urandom_range(0, 99) < 45) begin
            case ($urandom_range(0, 9))
               0: len = 1;
               1: len = 128;
               default: len = $urandom_range(2, 127);
            endcase
            push_byte(8'h80 | 8'(len - 1));
            random_pixel(with_alpha);
            pixels += len;
         end else begin
            len = ($urandom_range(0, 29) == 0) ? 128 : $urandom_range(1, 6);
            push_byte(8'(len - 1));
            repeat (len) random_pixel(with_alpha);
            pixels += len;
         end
      end

      // in run-length files a closing packet overruns the image end
      if (!rle) begin
         total = pixels;
      end else if ($urandom_range(0, 1)) begin
         n = $urandom_range(2, 128);
         k = $urandom_range(1, n - 1);
         push_byte(8'h80 | 8'(n - 1));
         random_pixel(with_alpha);
         total = pixels + k;
      end else begin
         n = $urandom_range(2, 8);
         k = $urandom_range(1, n - 1);
         push_byte(8'(n - 1));
         repeat (n) random_pixel(with_alpha);
         total = pixels + k;
      end
      // trailing bytes land in the done phase
      repeat (20) push_byte(8'($urandom_range(0, 255)));

      for (h = 255; h > 1; h--) begin
         if (total % h == 0 && total / h <= 65535) break;
      end
      file_h = 16'(h);
      file_w = 16'(total / h);

      for (int i = 0; i < trd_pkg::HDR_LEN; i++) begin
         case (i)
            trd_pkg::IDX_TYPE:    d = file_type;
            trd_pkg::IDX_WIDTH_L: d = file_w[7:0];
            trd_pkg::IDX_WIDTH_H: d = file_w[15:8];
            trd_pkg::IDX_HGT_L:   d = file_h[7:0];
            trd_pkg::IDX_HGT_H:   d = file_h[15:8];
            trd_pkg::IDX_DEPTH:   d = file_depth;
            default:              d = 8'($urandom_range(0, 255));
         endcase
         head.push_back('{data: d, pinned: 1'b0, want: '0});
      end
      foreach (tga_file[i]) begin
         if (tga_file[i].pinned) begin
            tga_file[i].want.image_width  = file_w;
            tga_file[i].want.image_height = file_h;
         end
      end
      tga_file = {head, tga_file};
   endtask

   task automatic check_pixel(input trd_pkg::rsp_type want, input trd_pkg::rsp_type got);
      if (got.red !== want.red) begin
         $error("red: expected %0d, got %0d", want.red, got.red);
         mismatch_cnt++;
      end
      if (got.green !== want.green) begin
         $error("green: expected %0d, got %0d", want.green, got.green);
         mismatch_cnt++;
      end
      if (got.blue !== want.blue) begin
         $error("blue: expected %0d, got %0d", want.blue, got.blue);
         mismatch_cnt++;
      end
      if (got.alpha !== want.alpha) begin
         $error("alpha: expected %0d, got %0d", want.alpha, got.alpha);
         mismatch_cnt++;
      end
      if (got.repeat_count !== want.repeat_count) begin
         $error("repeat_count: expected %0d, got %0d", want.repeat_count, got.repeat_count);
         mismatch_cnt++;
      end
      if (got.image_width !== want.image_width) begin
         $error("image_width: expected %0d, got %0d", want.image_width, got.image_width);
         mismatch_cnt++;
      end
      if (got.image_height !== want.image_height) begin
         $error("image_height: expected %0d, got %0d", want.image_height, got.image_height);
         mismatch_cnt++;
      end
      if (got.is_last !== want.is_last) begin
         $error("is_last: expected %0d, got %0d", want.is_last, got.is_last);
         mismatch_cnt++;
      end
      if (got.status !== want.status) begin
         $error("status: expected %0d, got %0d", want.status, got.status);
         mismatch_cnt++;
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

   initial begin : sender
      int unsigned send_idle, n;
      req_ch.valid     = 1'b0;
      req_ch.data_byte = '0;
      clear_decoder();
      build_file();
      n = tga_file.size();
      @(posedge clock);
      while (reset) @(posedge clock);
      foreach (tga_file[i]) begin
         if (i == n / 3 || i == 2 * n / 3) begin
            // drain before switching idle pattern
            req_ch.valid <= 1'b0;
            @(posedge clock);
            while (pixel_q.size() != 0) @(posedge clock);
            idle_phase++;
            if (idle_phase == 2) hold_go = 1'b1;
         end
         send_idle = (idle_phase == 0) ? 17 : (idle_phase == 1) ? 65 : 0;
         while ($urandom_range(0, 99) < send_idle) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
         end
         req_ch.valid     <= 1'b1;
         req_ch.data_byte <= tga_file[i].data;
         @(posedge clock);
         while (!req_ch.ready) @(posedge clock);
      end
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pixel_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("%0d-bit %s image %0dx%0d: %0d file bytes accepted, %0d pixel results checked",
               file_depth, (file_type == trd_pkg::TYPE_RAW) ? "raw" : "run-length",
               file_w, file_h, accepted_cnt, checked_cnt);
      if (mismatch_cnt == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin : receiver
      int unsigned stall;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go) begin
            // long back-pressure while the sender keeps offering bytes
            hold_go = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         stall = (idle_phase == 0) ? 65 : (idle_phase == 1) ? 17 : 0;
         rsp_ch.ready <= ($urandom_range(0, 99) >= stall);
      end
   end

   always @(posedge clock) begin : accept_monitor
      bit               emitted;
      trd_pkg::rsp_type pix;
      if (!reset && req_ch.valid && req_ch.ready) begin
         decode_byte(req_ch.data_byte, emitted, pix);
         if (emitted) begin
            pixel_q.push_back(tga_file[accepted_cnt].pinned ? tga_file[accepted_cnt].want : pix);
         end
         accepted_cnt++;
      end
   end

   always @(posedge clock) begin : result_monitor
      trd_pkg::rsp_type got;
      trd_pkg::rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = {rsp_ch.red, rsp_ch.green, rsp_ch.blue, rsp_ch.alpha, rsp_ch.repeat_count,
                rsp_ch.image_width, rsp_ch.image_height, rsp_ch.is_last, rsp_ch.status};
         if (pixel_q.size() == 0) begin
            $error("pixel result with nothing expected");
            mismatch_cnt++;
         end else begin
            want = pixel_q.pop_front();
            check_pixel(want, got);
            checked_cnt++;
         end
      end
   end

endmodule
